// ===== sv/lsms_pkg.sv =====
// Shared types and constants for the load/store-multiple sequencer.
package lsms_pkg;

  localparam int unsigned NumRegs   = 16;
  localparam int unsigned RegIdxW   = $clog2(NumRegs);
  localparam int unsigned WordW     = 32;
  localparam int unsigned KindW     = 2;

  localparam logic [WordW-1:0] WordBytes = WordW'(4);

  // Instruction word bit positions
  localparam int unsigned BitPre   = 24;
  localparam int unsigned BitUp    = 23;
  localparam int unsigned BitWb    = 21;
  localparam int unsigned BitLoad  = 20;
  localparam int unsigned BaseLsb  = 16;

  // Access kind codes
  localparam logic [KindW-1:0] KindLoad  = KindW'(0);
  localparam logic [KindW-1:0] KindStore = KindW'(1);
  localparam logic [KindW-1:0] KindWb    = KindW'(2);

  // Next register chosen from the remaining list
  typedef struct packed {
    logic               found;
    logic [RegIdxW-1:0] idx;
    logic [NumRegs-1:0] rest;
  } pick_t;

endpackage

// ===== sv/lsms_if.sv =====
// Channel interfaces for instruction beats and access beats.
interface lsms_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  logic [31:0] base_value;

  modport source (output valid, output instruction_word, output base_value, input ready);
  modport sink (input valid, input instruction_word, input base_value, output ready);
  modport monitor (input valid, input instruction_word, input base_value, input ready);
endinterface

interface lsms_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  access_kind;
  logic [3:0]  register_index;
  logic [31:0] access_address;
  logic        last_result;

  modport source (output valid, output access_kind, output register_index,
                  output access_address, output last_result, input ready);
  modport sink (input valid, input access_kind, input register_index,
                input access_address, input last_result, output ready);
  modport monitor (input valid, input access_kind, input register_index,
                   input access_address, input last_result, input ready);
endinterface

// ===== sv/lsms_pick.sv =====
// Finds the next register to transfer in the remaining register list.
module lsms_pick (
  input  logic [lsms_pkg::NumRegs-1:0] list_i,
  input  logic                         up_i,
  output lsms_pkg::pick_t              pick_o
);
  import lsms_pkg::*;

  logic               found;
  logic [RegIdxW-1:0] idx;

  // Lowest set bit when counting up, highest when counting down.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < NumRegs; i++) begin
      if (up_i) begin
        if (!found && list_i[i]) begin
          found = 1'b1;
          idx   = RegIdxW'(i);
        end
      end else begin
        if (!found && list_i[NumRegs-1-i]) begin
          found = 1'b1;
          idx   = RegIdxW'(NumRegs-1-i);
        end
      end
    end
  end

  always_comb begin
    pick_o.found   = found;
    pick_o.idx     = idx;
    pick_o.rest    = list_i;
    pick_o.rest[idx] = 1'b0;
  end

endmodule

// ===== sv/lsms_step_unit.sv =====
// Shared address adder: steps the running address by one word up or down.
module lsms_step_unit (
  input  logic [lsms_pkg::WordW-1:0] addr_i,
  input  logic                       up_i,
  output logic [lsms_pkg::WordW-1:0] next_o
);
  import lsms_pkg::*;

  // Wraps modulo 2^32 in both directions.
  assign next_o = up_i ? (addr_i + WordBytes) : (addr_i - WordBytes);

endmodule

// ===== sv/load_store_multiple_sequencer.sv =====
// Top level: block-transfer address sequencer with registered access output.
//
//   channel  dir  payload                                         handshake
//   in_i     in   instruction_word, base_value                    valid/ready
//   out_o    out  access_kind, register_index, access_address,    valid/ready
//                 last_result
//
// One access beat per listed register, then an optional writeback beat: up to
// 17 beats per instruction, one per cycle while out_o is not stalled. The
// rate is set by the single address adder and the register picker, which
// handle one register per cycle. in_i is ready only between instructions; an
// instruction with an empty list and no writeback is taken and dropped
// without leaving idle. Reset is asynchronous and clears the sequencer and
// output valid.
module load_store_multiple_sequencer (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsms_in_if.sink    in_i,
  lsms_out_if.source out_o
);
  import lsms_pkg::*;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e             state_q;
  logic [NumRegs-1:0] list_q;
  logic               pre_q;
  logic               up_q;
  logic               wb_q;
  logic               load_q;
  logic [RegIdxW-1:0] base_idx_q;
  logic [WordW-1:0]   addr_q;

  logic               out_valid_q;
  logic [KindW-1:0]   out_kind_q;
  logic [RegIdxW-1:0] out_idx_q;
  logic [WordW-1:0]   out_addr_q;
  logic               out_last_q;

  pick_t              pick;
  logic [WordW-1:0]   addr_next;
  logic               in_fire;
  logic               advance;
  logic               in_busy;

  lsms_pick u_pick (
    .list_i (list_q),
    .up_i   (up_q),
    .pick_o (pick)
  );

  lsms_step_unit u_step (
    .addr_i (addr_q),
    .up_i   (up_q),
    .next_o (addr_next)
  );

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  // Produce the next beat whenever the output register is free or draining.
  assign advance    = (state_q == StRun) && (!out_valid_q || out_o.ready);
  assign in_busy    = (in_i.instruction_word[NumRegs-1:0] != '0) ||
                      in_i.instruction_word[BitWb];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            list_q     <= in_i.instruction_word[NumRegs-1:0];
            pre_q      <= in_i.instruction_word[BitPre];
            up_q       <= in_i.instruction_word[BitUp];
            wb_q       <= in_i.instruction_word[BitWb];
            load_q     <= in_i.instruction_word[BitLoad];
            base_idx_q <= in_i.instruction_word[BaseLsb +: RegIdxW];
            addr_q     <= in_i.base_value;
            if (in_busy) begin
              state_q <= StRun;
            end
          end
        end
        StRun: begin
          if (advance) begin
            if (pick.found) begin
              out_kind_q <= load_q ? KindLoad : KindStore;
              out_idx_q  <= pick.idx;
              out_addr_q <= pre_q ? addr_next : addr_q;
              out_last_q <= (pick.rest == '0) && !wb_q;
              addr_q     <= addr_next;
              list_q     <= pick.rest;
              if ((pick.rest == '0) && !wb_q) begin
                state_q <= StIdle;
              end
            end else begin
              out_kind_q <= KindWb;
              out_idx_q  <= base_idx_q;
              out_addr_q <= addr_q;
              out_last_q <= 1'b1;
              state_q    <= StIdle;
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
      // Load a produced beat, else drop a drained one.
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.access_kind    = out_kind_q;
  assign out_o.register_index = out_idx_q;
  assign out_o.access_address = out_addr_q;
  assign out_o.last_result    = out_last_q;

endmodule

// ===== sv/lsms_checker.sv =====
// Port-level checks for the load/store-multiple sequencer, bound to the top.
module lsms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  lsms_in_if.sink    in_i,
  lsms_out_if.source out_o
);
  import lsms_pkg::*;

  logic in_fire;
  logic in_empty;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_empty = (in_i.instruction_word[NumRegs-1:0] == '0) &&
                    !in_i.instruction_word[BitWb];

  // An instruction that causes beats holds off the next one.
  a_busy_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_empty |=> !in_i.ready)
    else $error("input ready right after an instruction with work");

  // An instruction without beats is dropped at once.
  a_ready_after_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_empty |=> in_i.ready)
    else $error("input stalled after an instruction with no beats");

  // The writeback beat always ends an instruction.
  a_wb_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.access_kind == KindWb) |-> out_o.last_result)
    else $error("writeback beat not flagged last");

  // Hold a stalled beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.access_address))
    else $error("stalled output beat dropped or changed");

endmodule

bind load_store_multiple_sequencer lsms_checker u_lsms_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);
